FILE: rtl/core/rctb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rctb_pkg - resize coefficient table builder package
// Payload structs, result status codes and the axis mode type.
// ----------------------------------------------------------------------------
package rctb_pkg;

    // Request transaction: source and requested output size
    typedef struct packed {
        logic [11:0] src_width;
        logic [11:0] src_height;
        logic [11:0] req_width;
        logic [11:0] req_height;
    } t_in;

    // Result transaction: table word or final summary
    typedef struct packed {
        logic        kind;
        logic [5:0]  entry_index;
        logic [7:0]  entry_word;
        logic [31:0] size_word;
        logic [31:0] index_word;
        logic [11:0] final_width;
        logic [11:0] final_height;
        logic [2:0]  status;
        logic        last;
    } t_out;

    // Summary status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_X   = 3'd1;
    localparam logic [2:0] ST_RETRY_X = 3'd2;
    localparam logic [2:0] ST_BAD_Y   = 3'd3;
    localparam logic [2:0] ST_RETRY_Y = 3'd4;

    // Result kinds
    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Filler word that follows a long source step
    localparam logic [7:0] SPILL_WORD = 8'h02;

    // Divider widths: dividend holds c*32 + base/2, divisor holds the base
    localparam int DIV_DW = 21;
    localparam int DIV_SW = 15;

    // Axis resize modes
    typedef enum logic [1:0] {
        MODE_UNITY,
        MODE_UP,
        MODE_DOWN,
        MODE_BILIN
    } t_mode;

endpackage
`default_nettype wire

FILE: rtl/core/rctb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rctb_ram - generic single write port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/core/resize_coefficient_table_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resize_coefficient_table_builder - resize coefficient table builder
// Reduces each axis ratio by its GCD, builds the coefficient words with
// output-size retries, then streams the table (none on failure) and one summary transaction.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready    i_in_data  (t_in)
//   out      output     o_out_valid / i_out_ready  o_out_data (t_out)
//
// One request is worked at a time; o_in_ready is high only when idle.
// Every mod, quotient and weight goes through one shared restoring divider;
// an attempt costs one division per GCD step, two for the reduced ratio and
// one per coefficient word.
// Reset is synchronous; no clearing pass. Output stalls hold the emit phase.
// ----------------------------------------------------------------------------
module resize_coefficient_table_builder #(
    parameter int TABLE_DEPTH = 40,
    parameter int RETRY_LIMIT = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire rctb_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output rctb_pkg::t_out       o_out_data
);

    localparam int KW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = rctb_pkg::DIV_DW;
    localparam int SW = rctb_pkg::DIV_SW;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [22:0] {
        S_IDLE      = 23'h000001,
        S_AXIS_INIT = 23'h000002,
        S_TRY       = 23'h000004,
        S_GCD       = 23'h000008,
        S_GCD_R     = 23'h000010,
        S_GOT_N     = 23'h000020,
        S_GOT_D     = 23'h000040,
        S_MODE      = 23'h000080,
        S_UP        = 23'h000100,
        S_DN        = 23'h000200,
        S_DN_SUB    = 23'h000400,
        S_BL        = 23'h000800,
        S_BL_ADV    = 23'h001000,
        S_WT        = 23'h002000,
        S_WORD      = 23'h004000,
        S_PUT       = 23'h008000,
        S_NEXT      = 23'h010000,
        S_AXIS_OK   = 23'h020000,
        S_RETRY     = 23'h040000,
        S_DIV       = 23'h080000,
        S_RD        = 23'h100000,
        S_RDW       = 23'h200000,
        S_SUM       = 23'h400000
    } t_state;

    t_state           r_state, n_state, r_ret, n_ret;
    rctb_pkg::t_in    r_in, n_in;
    rctb_pkg::t_mode  r_mode, n_mode;
    rctb_pkg::t_out   r_out, n_out;
    logic             r_ovalid, n_ovalid;
    logic             r_axis, n_axis;
    logic [11:0]      r_src, n_src;
    logic [12:0]      r_t, n_t;
    logic [4:0]       r_retry, n_retry;
    logic [12:0]      r_ga, n_ga, r_gb, n_gb;
    logic [12:0]      r_num, n_num, r_den, n_den;
    logic [12:0]      r_nx, n_nx, r_dx, n_dx;
    logic [KW-1:0]    r_k, n_k, r_k0, n_k0;
    logic [KW-1:0]    r_hlen, n_hlen, r_vlen, n_vlen, r_i, n_i;
    logic [DW-1:0]    r_v, n_v, r_outpos, n_outpos, r_carry, n_carry;
    logic [12:0]      r_inc, n_inc;
    logic [12:0]      r_step, n_step, r_wcnt, n_wcnt;
    logic [SW-1:0]    r_c, n_c, r_base, n_base;
    logic [7:0]       r_word, n_word;
    logic [12:0]      r_aw, n_aw, r_ah, n_ah;
    logic [2:0]       r_status, n_status;
    logic [DW-1:0]    r_quo, n_quo;
    logic [SW-1:0]    r_rem, n_rem, r_dvs, n_dvs;
    logic [CW-1:0]    r_dcnt, n_dcnt;

    logic             w_we, w_re, w_free;
    logic [7:0]       w_rdata;
    logic [SW:0]      w_rem_sh;
    logic [SW:0]      w_rem_sub;
    logic [4:0]       w_wt;
    logic [DW-1:0]    w_sum;
    logic [DW-1:0]    w_start;
    logic [31:0]      w_hlen32, w_vlen32;

    rctb_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_k[AW-1:0]),
        .i_wdata (r_word),
        .i_re    (w_re),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Shared divider step and word weight shaping
    always_comb begin
        w_rem_sh  = {r_rem, r_quo[DW-1]};
        w_rem_sub = w_rem_sh - {1'b0, r_dvs};
        if (r_quo >= DW'(31)) begin
            w_wt = 5'(r_quo - DW'(1));
        end else if (r_quo == DW'(1)) begin
            w_wt = 5'd2;
        end else begin
            w_wt = r_quo[4:0];
        end
        w_sum    = r_v + DW'(r_num);
        w_start  = DW'(r_num) - DW'(r_den);
        w_hlen32 = 32'(r_hlen);
        w_vlen32 = 32'(r_vlen);
    end

    assign w_free      = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Sequencer
    always_comb begin
        n_state  = r_state;  n_ret    = r_ret;    n_in     = r_in;
        n_mode   = r_mode;   n_out    = r_out;    n_axis   = r_axis;
        n_src    = r_src;    n_t      = r_t;      n_retry  = r_retry;
        n_ga     = r_ga;     n_gb     = r_gb;     n_num    = r_num;
        n_den    = r_den;    n_nx     = r_nx;     n_dx     = r_dx;
        n_k      = r_k;      n_k0     = r_k0;     n_hlen   = r_hlen;
        n_vlen   = r_vlen;   n_i      = r_i;      n_v      = r_v;
        n_outpos = r_outpos; n_carry  = r_carry;  n_inc    = r_inc;
        n_step   = r_step;   n_wcnt   = r_wcnt;   n_c      = r_c;
        n_base   = r_base;   n_word   = r_word;   n_aw     = r_aw;
        n_ah     = r_ah;     n_status = r_status; n_quo    = r_quo;
        n_rem    = r_rem;    n_dvs    = r_dvs;    n_dcnt   = r_dcnt;
        n_ovalid = r_ovalid && !i_out_ready;
        w_we     = 1'b0;
        w_re     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_axis  = 1'b0;
                    n_state = S_AXIS_INIT;
                end
            end
            // Load one axis and its retry budget
            S_AXIS_INIT: begin
                n_src   = r_axis ? r_in.src_height : r_in.src_width;
                n_t     = 13'(r_axis ? r_in.req_height : r_in.req_width);
                n_retry = 5'(RETRY_LIMIT);
                n_k0    = r_axis ? r_hlen : '0;
                n_state = S_TRY;
            end
            S_TRY: begin
                if (r_src == '0 || r_t == '0) begin
                    n_status = r_axis ? rctb_pkg::ST_BAD_Y : rctb_pkg::ST_BAD_X;
                    n_state  = S_SUM;
                end else begin
                    n_ga    = 13'(r_src);
                    n_gb    = r_t;
                    n_state = S_GCD;
                end
            end
            // Euclid: one remainder per divider pass
            S_GCD: begin
                n_rem   = '0;
                n_dcnt  = CW'(DW);
                n_state = S_DIV;
                if (r_gb == '0) begin
                    n_quo = DW'(r_src);
                    n_dvs = SW'(r_ga);
                    n_ret = S_GOT_N;
                end else begin
                    n_quo = DW'(r_ga);
                    n_dvs = SW'(r_gb);
                    n_ret = S_GCD_R;
                end
            end
            S_GCD_R: begin
                n_ga    = r_gb;
                n_gb    = 13'(r_rem);
                n_state = S_GCD;
            end
            S_GOT_N: begin
                n_num   = 13'(r_quo);
                n_quo   = DW'(r_t);
                n_dvs   = SW'(r_ga);
                n_rem   = '0;
                n_dcnt  = CW'(DW);
                n_ret   = S_GOT_D;
                n_state = S_DIV;
            end
            S_GOT_D: begin
                n_den = 13'(r_quo);
                n_k   = r_k0;
                if (r_axis && r_num == r_nx && 13'(r_quo) == r_dx) begin
                    n_state = S_AXIS_OK;
                end else begin
                    n_state = S_MODE;
                end
            end
            // Pick the mode and seed its accumulators
            S_MODE: begin
                n_v = '0;
                if (r_num == r_den) begin
                    n_mode  = rctb_pkg::MODE_UNITY;
                    n_c     = SW'(1);
                    n_base  = SW'(1);
                    n_step  = 13'd1;
                    n_state = S_WT;
                end else if (r_num < r_den) begin
                    n_mode  = rctb_pkg::MODE_UP;
                    n_state = S_UP;
                end else if (14'(r_num) >= {r_den, 1'b0}) begin
                    n_mode  = rctb_pkg::MODE_DOWN;
                    n_inc   = 13'(14'(r_num) - {r_den, 1'b0});
                    n_state = S_DN;
                end else begin
                    n_mode   = rctb_pkg::MODE_BILIN;
                    n_v      = DW'(r_den) + DW'({r_den, 1'b0});
                    n_outpos = DW'(r_num);
                    n_carry  = w_start;
                    n_state  = S_BL;
                end
            end
            S_UP: begin
                n_c    = SW'(r_den) - SW'(r_v);
                n_base = SW'(r_den);
                if (w_sum >= DW'(r_den)) begin
                    n_v    = w_sum - DW'(r_den);
                    n_step = 13'd1;
                end else begin
                    n_v    = w_sum;
                    n_step = 13'd0;
                end
                n_state = S_WT;
            end
            S_DN: begin
                n_v     = r_v + DW'(r_inc);
                n_step  = 13'd2;
                n_state = S_DN_SUB;
            end
            S_DN_SUB: begin
                if (r_v >= DW'(r_den)) begin
                    n_v    = r_v - DW'(r_den);
                    n_step = r_step + 13'd1;
                end else begin
                    n_c     = SW'(1);
                    n_base  = SW'(2);
                    n_state = S_WT;
                end
            end
            S_BL: begin
                n_c      = SW'(r_v - r_outpos);
                n_outpos = r_outpos + DW'({r_num, 1'b0});
                n_carry  = r_carry + DW'({r_num, 1'b0});
                n_step   = 13'd0;
                n_state  = S_BL_ADV;
            end
            S_BL_ADV: begin
                if (r_v < r_outpos) begin
                    n_v     = r_v + DW'({r_den, 1'b0});
                    n_carry = r_carry - DW'({r_den, 1'b0});
                    n_step  = r_step + 13'd1;
                end else begin
                    n_base  = SW'({r_den, 1'b0});
                    n_state = S_WT;
                end
            end
            // Weight = (c*32 + base/2) / base
            S_WT: begin
                n_quo   = DW'({r_c, 5'b0}) + DW'(r_base >> 1);
                n_dvs   = r_base;
                n_rem   = '0;
                n_dcnt  = CW'(DW);
                n_ret   = S_WORD;
                n_state = S_DIV;
            end
            S_WORD: begin
                if (r_step < 13'd4) begin
                    n_word = {w_wt, r_step[1:0], 1'b1};
                    n_wcnt = '0;
                end else begin
                    n_word = {w_wt, 2'd1, 1'b1};
                    n_wcnt = r_step - 13'd1;
                end
                n_state = S_PUT;
            end
            // Write words; a write past the end fails the attempt
            S_PUT: begin
                if (r_k >= KW'(TABLE_DEPTH)) begin
                    n_state = S_RETRY;
                end else begin
                    w_we = 1'b1;
                    n_k  = r_k + KW'(1);
                    if (r_wcnt != '0) begin
                        n_word = rctb_pkg::SPILL_WORD;
                        n_wcnt = r_wcnt - 13'd1;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                case (r_mode)
                    rctb_pkg::MODE_UP:
                        n_state = (r_v != '0) ? S_UP : S_AXIS_OK;
                    rctb_pkg::MODE_DOWN:
                        n_state = (r_v != '0) ? S_DN : S_AXIS_OK;
                    rctb_pkg::MODE_BILIN:
                        n_state = (r_carry != w_start) ? S_BL : S_AXIS_OK;
                    default:
                        n_state = S_AXIS_OK;
                endcase
            end
            S_AXIS_OK: begin
                if (!r_axis) begin
                    n_hlen  = r_k;
                    n_aw    = r_t;
                    n_nx    = r_num;
                    n_dx    = r_den;
                    n_axis  = 1'b1;
                    n_state = S_AXIS_INIT;
                end else begin
                    n_vlen   = r_k;
                    n_ah     = r_t;
                    n_i      = '0;
                    n_status = rctb_pkg::ST_OK;
                    n_state  = S_RD;
                end
            end
            // Raise the output size by one and try again, or fail once the retry budget is spent
            S_RETRY: begin
                n_t = r_t + 13'd1;
                if (r_retry == '0) begin
                    n_status = r_axis ? rctb_pkg::ST_RETRY_Y : rctb_pkg::ST_RETRY_X;
                    n_state  = S_SUM;
                end else begin
                    n_retry = r_retry - 5'd1;
                    n_state = S_TRY;
                end
            end
            // Restoring divide: one quotient bit per cycle
            S_DIV: begin
                if (!w_rem_sub[SW]) begin
                    n_rem = w_rem_sub[SW-1:0];
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[SW-1:0];
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end
                n_dcnt = r_dcnt - CW'(1);
                if (r_dcnt == CW'(1)) begin
                    n_state = r_ret;
                end
            end
            S_RD: begin
                w_re    = 1'b1;
                n_state = S_RDW;
            end
            // Drain the table into the output register
            S_RDW: begin
                if (w_free) begin
                    n_ovalid          = 1'b1;
                    n_out             = '0;
                    n_out.kind        = rctb_pkg::KIND_WORD;
                    n_out.entry_index = 6'(r_i);
                    n_out.entry_word  = w_rdata;
                    n_i               = r_i + KW'(1);
                    n_state           = (r_i + KW'(1) == r_vlen) ? S_SUM : S_RD;
                end
            end
            S_SUM: begin
                if (w_free) begin
                    n_ovalid     = 1'b1;
                    n_out        = '0;
                    n_out.kind   = rctb_pkg::KIND_SUMMARY;
                    n_out.status = r_status;
                    n_out.last   = 1'b1;
                    if (r_status == rctb_pkg::ST_OK) begin
                        n_out.size_word    = {3'b0, r_aw, 3'b0, r_ah};
                        n_out.index_word   = ((w_hlen32 - 32'd1) << 16)
                                           | ((r_vlen == r_hlen) ? 32'd0 : (w_hlen32 << 8))
                                           | (w_vlen32 - 32'd1);
                        n_out.final_width  = {r_aw[11:1], 1'b0};
                        n_out.final_height = r_ah[11:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state with reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_axis   <= 1'b0;
            r_retry  <= '0;
            r_k      <= '0;
            r_hlen   <= '0;
            r_t      <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_axis   <= n_axis;
            r_retry  <= n_retry;
            r_k      <= n_k;
            r_hlen   <= n_hlen;
            r_t      <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;    r_in     <= n_in;     r_mode   <= n_mode;
        r_out    <= n_out;    r_src    <= n_src;    r_ga     <= n_ga;
        r_gb     <= n_gb;     r_num    <= n_num;    r_den    <= n_den;
        r_nx     <= n_nx;     r_dx     <= n_dx;     r_k0     <= n_k0;
        r_vlen   <= n_vlen;   r_i      <= n_i;      r_v      <= n_v;
        r_outpos <= n_outpos; r_carry  <= n_carry;  r_inc    <= n_inc;
        r_step   <= n_step;   r_wcnt   <= n_wcnt;   r_c      <= n_c;
        r_base   <= n_base;   r_word   <= n_word;   r_aw     <= n_aw;
        r_ah     <= n_ah;     r_status <= n_status; r_quo    <= n_quo;
        r_rem    <= n_rem;    r_dvs    <= n_dvs;    r_dcnt   <= n_dcnt;
    end

    // Divider never runs on a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0))
        else $error("divider started with zero divisor");

    // Table position never passes the table end
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(TABLE_DEPTH))
        else $error("table position out of range");

    // A table write always lands inside the table
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_k < KW'(TABLE_DEPTH)))
        else $error("table write past end");

    // Result is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> $stable(r_out))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

FILE: dv/tb_resize_coefficient_table_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resize_coefficient_table_builder - resize table builder testbench
// Sends resize requests through a queue-fed driver, predicts the coefficient
// words and the summary of each request, and checks every result transaction
// against the predicted stream, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_resize_coefficient_table_builder;
    import rctb_pkg::*;

    localparam int     TABLE_DEPTH = 40;
    localparam int     RETRY_LIMIT = 16;
    localparam int     STALL_LIMIT = 400000;
    localparam longint SIZE_MASK   = 64'h1FFF;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    t_in         pending_reqs[$];
    t_out        expected_results[$];
    logic [7:0]  coef_shadow[TABLE_DEPTH];
    int          n_sent;
    int          n_results;
    int          n_mismatch;
    int          n_ok;
    int          n_err;
    int          quiet_cycles;
    logic        calm;

    resize_coefficient_table_builder #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .RETRY_LIMIT(RETRY_LIMIT)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // no idling on either side for a stretch in the middle of the run
    assign calm = (n_sent >= 60) && (n_sent < 90);

    function automatic longint gcd_l(input longint a, input longint b);
        longint t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic bit store_coef(input longint k, input longint w);
        if (k < 0 || k >= TABLE_DEPTH) return 1'b0;
        coef_shadow[k] = w[7:0];
        return 1'b1;
    endfunction

    // Encode one weight/step pair; spill long steps into filler words
    function automatic longint encode_coef(input longint k, input longint num,
                                           input longint base, input longint step);
        longint w;
        longint word;
        longint rem;
        w = (num * 32 + base / 2) / base;
        if (w >= 31) w--;
        else if (w == 1) w = 2;
        w &= 31;
        if (step < 4) begin
            word = (((w << 2) | step) << 1) | 1;
        end else begin
            rem  = step - 1;
            word = (((w << 2) | 1) << 1) | 1;
            do begin
                if (!store_coef(k, word)) return -1;
                k++;
                word = ((rem > 1) ? 1 : rem) << 1;
                rem--;
            end while (rem > 0);
        end
        if (!store_coef(k, word)) return -1;
        return k + 1;
    endfunction

    // Build one axis from k; return next position or -1 on overflow
    function automatic longint build_axis(input longint num, input longint den,
                                          input longint k);
        longint v, c, step, in_inc, out_pos, out_inc, start, carry;
        v = 0;
        if (num == den) return encode_coef(k, 1, 1, 1);
        if (num < den) begin
            do begin
                c = den - v;
                step = 0;
                v += num;
                if (v >= den) begin
                    v -= den;
                    step = 1;
                end
                k = encode_coef(k, c, den, step);
                if (k < 0) return -1;
            end while (v != 0);
        end else if (num >= 2 * den) begin
            c = num - 2 * den;
            do begin
                step = 2;
                v += c;
                while (v >= den) begin
                    v -= den;
                    step++;
                end
                k = encode_coef(k, 1, 2, step);
                if (k < 0) return -1;
            end while (v != 0);
        end else begin
            in_inc  = 2 * den;
            out_pos = num;
            out_inc = 2 * num;
            start   = num - den;
            carry   = start;
            v       = den + in_inc;
            do begin
                c = v - out_pos;
                step = 0;
                out_pos += out_inc;
                carry += out_inc;
                while (v < out_pos) begin
                    v += in_inc;
                    carry -= in_inc;
                    step++;
                end
                k = encode_coef(k, c, in_inc, step);
                if (k < 0) return -1;
            end while (carry != start);
        end
        return k;
    endfunction

    // Fit one axis with size retries: length, 0 bad ratio, -1 exhausted
    function automatic longint fit_axis(input longint src, input longint req,
                                        input longint k0, input bit share,
                                        input longint sn, input longint sd,
                                        output longint rn, output longint rd,
                                        output longint used);
        longint t, g, len;
        int     retries;
        t = req;
        retries = RETRY_LIMIT;
        rn = 0;
        rd = 0;
        forever begin
            used = t;
            if (src == 0 || t == 0) return 0;
            g  = gcd_l(src, t);
            rn = src / g;
            rd = t / g;
            if (share && rn == sn && rd == sd) return k0;
            len = build_axis(rn, rd, k0);
            if (len >= 0) return len;
            t = (t + 1) & SIZE_MASK;
            if (retries == 0) return -1;
            retries--;
        end
    endfunction

    function automatic t_out summary_of(input logic [2:0] st);
        t_out s;
        s = '0;
        s.kind   = KIND_SUMMARY;
        s.status = st;
        s.last   = 1'b1;
        return s;
    endfunction

    // Predict the full result stream of one accepted request
    task automatic predict_table(input t_in req);
        longint nx, dx, ny, dy, aw, ah, hlen, vlen;
        t_out   r;
        int     i;
        hlen = fit_axis(req.src_width, req.req_width, 0, 1'b0, 0, 0, nx, dx, aw);
        if (hlen <= 0) begin
            expected_results.push_back(summary_of(hlen == 0 ? ST_BAD_X : ST_RETRY_X));
            n_err++;
            return;
        end
        vlen = fit_axis(req.src_height, req.req_height, hlen, 1'b1, nx, dx, ny, dy, ah);
        if (vlen <= 0) begin
            expected_results.push_back(summary_of(vlen == 0 ? ST_BAD_Y : ST_RETRY_Y));
            n_err++;
            return;
        end
        for (i = 0; i < vlen && i < TABLE_DEPTH; i++) begin
            r = '0;
            r.kind        = KIND_WORD;
            r.entry_index = 6'(i);
            r.entry_word  = coef_shadow[i];
            expected_results.push_back(r);
        end
        r = summary_of(ST_OK);
        r.size_word    = 32'((aw << 16) | ah);
        r.index_word   = 32'(((hlen - 1) << 16) | ((vlen == hlen) ? 0 : (hlen << 8))
                         | (vlen - 1));
        r.final_width  = 12'(aw & ~64'd1);
        r.final_height = 12'(ah);
        expected_results.push_back(r);
        n_ok++;
    endtask

    // Driver: hold a transaction until accepted, then maybe idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else begin
            if (i_in_valid && o_in_ready) predict_table(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 29)) begin
                    i_in_data  <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    n_sent     <= n_sent + 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each result transaction
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 29);
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: unexpected result kind=%0d status=%0d",
                                 o_out_data.kind, o_out_data.status);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_out_data.kind !== exp_r.kind
                        || o_out_data.entry_index !== exp_r.entry_index
                        || o_out_data.entry_word !== exp_r.entry_word
                        || o_out_data.size_word !== exp_r.size_word
                        || o_out_data.index_word !== exp_r.index_word
                        || o_out_data.final_width !== exp_r.final_width
                        || o_out_data.final_height !== exp_r.final_height
                        || o_out_data.status !== exp_r.status
                        || o_out_data.last !== exp_r.last) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("ERROR: result %0d mismatch", n_results);
                            $display("  exp kind=%0d idx=%0d word=%h size=%h iw=%h fw=%0d fh=%0d st=%0d last=%0d",
                                     exp_r.kind, exp_r.entry_index, exp_r.entry_word,
                                     exp_r.size_word, exp_r.index_word, exp_r.final_width,
                                     exp_r.final_height, exp_r.status, exp_r.last);
                            $display("  got kind=%0d idx=%0d word=%h size=%h iw=%h fw=%0d fh=%0d st=%0d last=%0d",
                                     o_out_data.kind, o_out_data.entry_index,
                                     o_out_data.entry_word, o_out_data.size_word,
                                     o_out_data.index_word, o_out_data.final_width,
                                     o_out_data.final_height, o_out_data.status,
                                     o_out_data.last);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: stop when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: watchdog expired");
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_req(input int iw, input int ih, input int rw, input int rh);
        t_in r;
        r.src_width  = 12'(iw);
        r.src_height = 12'(ih);
        r.req_width  = 12'(rw);
        r.req_height = 12'(rh);
        pending_reqs.push_back(r);
    endtask

    initial begin
        int n, d, f, n2, d2, f2, roll;
        n_sent = 0; n_results = 0; n_mismatch = 0; n_ok = 0; n_err = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each mode, sharing, zero sizes, extremes, spills, retries
        add_req(640, 480, 640, 480);
        add_req(320, 240, 640, 480);
        add_req(640, 480, 320, 240);
        add_req(640, 480, 480, 360);
        add_req(640, 480, 320, 480);
        add_req(0, 480, 320, 240);
        add_req(640, 0, 320, 240);
        add_req(640, 480, 0, 240);
        add_req(640, 480, 320, 0);
        add_req(4095, 4095, 4095, 4095);
        add_req(4095, 1, 1, 1);
        add_req(1, 4095, 1, 1);
        add_req(1, 1, 4095, 4095);
        add_req(7, 7, 41, 41);
        add_req(9, 9, 4, 4);
        add_req(5, 10, 1, 2);
        add_req(3, 6, 2, 3);
        add_req(12, 12, 40, 40);
        add_req(1, 1, 1, 1);
        add_req(4095, 4095, 2048, 2048);
        add_req(2730, 1365, 4095, 4095);
        add_req(100, 50, 103, 60);

        // random: mostly small reduced ratios, some raw noise
        repeat (118) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                add_req($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095));
            end else if (roll < 16) begin
                add_req($urandom_range(0, 1) * $urandom_range(1, 4095),
                        $urandom_range(0, 1) * $urandom_range(1, 4095),
                        $urandom_range(0, 1) * $urandom_range(1, 4095), 0);
            end else begin
                n = $urandom_range(1, 12);
                d = $urandom_range(1, 12);
                f = $urandom_range(1, 4095 / ((n > d) ? n : d));
                if ($urandom_range(0, 1)) begin
                    n2 = n; d2 = d;
                end else begin
                    n2 = $urandom_range(1, 12);
                    d2 = $urandom_range(1, 12);
                end
                f2 = $urandom_range(1, 4095 / ((n2 > d2) ? n2 : d2));
                add_req(n * f, n2 * f2, d * f, d2 * f2);
            end
        end

        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);

        $display("Covered %0d requests: %0d built tables, %0d error summaries, %0d results",
                 n_sent, n_ok, n_err, n_results);
        $display("Mismatches: %0d", n_mismatch);
        if (n_mismatch == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: resize_coefficient_table_builder.f
rtl/core/rctb_pkg.sv
rtl/core/rctb_ram.sv
rtl/core/resize_coefficient_table_builder.sv
dv/tb_resize_coefficient_table_builder.sv
